FILE: src/cms_pkg.sv
`timescale 1ns / 1ps
// cms_pkg: shared types and constants for the chair motor sequencer.
// Holds the mode encoding, register map, button and relay bit positions,
// and register reset values. No dependencies.
package cms_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_ZERO = 2'd1,
		MODE_WORK = 2'd2
	} mode_t;

	// register map, index = paddr[3:2]
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_AUTO_MOVE = 2'd1;
	localparam logic [1:0] REG_WATCHDOG = 2'd2;

	localparam int PADDR_W = 4;
	localparam int NUM_BUTTONS = 7;

	// button bit positions in the pin word
	localparam int BTN_SEAT_UP = 0;
	localparam int BTN_BACK_DOWN = 1;
	localparam int BTN_BACK_UP = 2;
	localparam int BTN_SEAT_DOWN = 3;
	localparam int BTN_LIGHT = 4;
	localparam int BTN_ZERO = 5;
	localparam int BTN_WORK = 6;

	// relay bit positions
	localparam int RLY_SEAT_UP = 0;
	localparam int RLY_SEAT_DOWN = 1;
	localparam int RLY_BACK_UP = 2;
	localparam int RLY_BACK_DOWN = 3;
	localparam int RLY_LIGHT = 4;

	// edge-detect bit positions
	localparam int EDGE_LIGHT = 0;
	localparam int EDGE_ZERO = 1;
	localparam int EDGE_WORK = 2;

	localparam logic [15:0] DEBOUNCE_RST = 16'd50;
	localparam logic [23:0] AUTO_MOVE_RST = 24'd30000;
	localparam logic [15:0] WATCHDOG_RST = 16'd500;

endpackage

FILE: src/chair_motor_sequencer.sv
`timescale 1ns / 1ps
// chair_motor_sequencer: button debounce, automatic seat moves, light toggle
// and watchdog toggling for a powered chair. Depends on cms_pkg.
//
//  channel   handshake                       payload
//  item      item_valid / item_ready         now_ms, buttons_pin_levels
//  result    result_valid / result_ready     relays, watchdog_pin, mode, return_done
//  config    psel/penable/pwrite, pready=1   paddr, pwdata, prdata
//
// An accepted word is evaluated from the input stage; its result loads when the
// result slot is free, one word per cycle sustained while result_ready is high.
// The control state itself is the result register, so the loaded result holds
// while result_ready is low; the input stage then holds one more word.
// Reset clears the control state to released buttons, idle, relays off.
module chair_motor_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [31:0] now_ms,
	input  logic [6:0]  buttons_pin_levels,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        seat_up_relay,
	output logic        seat_down_relay,
	output logic        back_up_relay,
	output logic        back_down_relay,
	output logic        light_relay,
	output logic        watchdog_pin,
	output logic [1:0]  mode,
	output logic        return_done,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [cms_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NB = cms_pkg::NUM_BUTTONS;

	// configuration
	logic [15:0] debounce_q;
	logic [23:0] auto_move_q;
	logic [15:0] wd_period_q;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	// input stage
	logic          valid_s1;
	logic [31:0]   now_s1;
	logic [NB-1:0] pins_s1;
	logic          advance;

	// control state, also the result register
	logic [NB-1:0]  stable_q;
	logic [NB-1:0]  last_raw_q;
	logic [31:0]    change_time_q [NB];
	logic [2:0]     prev_edges_q;
	cms_pkg::mode_t mode_q;
	logic           done_q;
	logic [31:0]    move_start_q;
	logic           light_on_q;
	logic [4:0]     relay_q;
	logic [31:0]    wd_last_q;
	logic           wd_level_q;
	logic           result_valid_q;

	// next-state logic
	logic [NB-1:0]  raw;
	logic [NB-1:0]  changed;
	logic [NB-1:0]  stable_n;
	logic [31:0]    btn_elapsed [NB];
	logic [31:0]    wd_elapsed;
	logic           wd_fire;
	logic [31:0]    move_elapsed;
	logic           move_timeout;
	logic           any_pressed;
	logic [2:0]     cur_edges;
	logic [2:0]     rise;
	cms_pkg::mode_t mode_n;
	logic           done_n;
	logic           light_on_n;
	logic [4:0]     relay_n;
	logic           move_start_we;
	logic [4:0]     manual_relays;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		case (cfg_idx)
			cms_pkg::REG_DEBOUNCE:  prdata = {16'd0, debounce_q};
			cms_pkg::REG_AUTO_MOVE: prdata = {8'd0, auto_move_q};
			cms_pkg::REG_WATCHDOG:  prdata = {16'd0, wd_period_q};
			default:                prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= cms_pkg::DEBOUNCE_RST;
			auto_move_q <= cms_pkg::AUTO_MOVE_RST;
			wd_period_q <= cms_pkg::WATCHDOG_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				cms_pkg::REG_DEBOUNCE:  debounce_q <= pwdata[15:0];
				cms_pkg::REG_AUTO_MOVE: auto_move_q <= pwdata[23:0];
				cms_pkg::REG_WATCHDOG:  wd_period_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// handshake: the stage word moves into state when the result slot frees
	assign advance      = valid_s1 & (~result_valid_q | result_ready);
	assign item_ready   = ~valid_s1 | advance;
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			now_s1  <= now_ms;
			pins_s1 <= buttons_pin_levels;
		end
	end

	always_comb begin
		raw        = ~pins_s1;
		wd_elapsed = now_s1 - wd_last_q;
		wd_fire    = wd_elapsed >= {16'd0, wd_period_q};

		for (int i = 0; i < NB; i++) begin
			changed[i]     = raw[i] != last_raw_q[i];
			btn_elapsed[i] = now_s1 - change_time_q[i];
			if (!changed[i] && stable_q[i] != raw[i] &&
			    btn_elapsed[i] >= {16'd0, debounce_q}) begin
				stable_n[i] = raw[i];
			end else begin
				stable_n[i] = stable_q[i];
			end
		end

		any_pressed  = |stable_n;
		cur_edges    = {stable_n[cms_pkg::BTN_WORK], stable_n[cms_pkg::BTN_ZERO],
		                stable_n[cms_pkg::BTN_LIGHT]};
		rise         = cur_edges & ~prev_edges_q;
		move_elapsed = now_s1 - move_start_q;
		move_timeout = move_elapsed >= {8'd0, auto_move_q};

		// opposing presses interlock to off
		manual_relays = 5'd0;
		manual_relays[cms_pkg::RLY_SEAT_UP] =
			stable_n[cms_pkg::BTN_SEAT_UP] & ~stable_n[cms_pkg::BTN_SEAT_DOWN];
		manual_relays[cms_pkg::RLY_SEAT_DOWN] =
			stable_n[cms_pkg::BTN_SEAT_DOWN] & ~stable_n[cms_pkg::BTN_SEAT_UP];
		manual_relays[cms_pkg::RLY_BACK_UP] =
			stable_n[cms_pkg::BTN_BACK_UP] & ~stable_n[cms_pkg::BTN_BACK_DOWN];
		manual_relays[cms_pkg::RLY_BACK_DOWN] =
			stable_n[cms_pkg::BTN_BACK_DOWN] & ~stable_n[cms_pkg::BTN_BACK_UP];

		mode_n        = mode_q;
		done_n        = done_q;
		light_on_n    = light_on_q;
		relay_n       = relay_q;
		move_start_we = 1'b0;

		case (mode_q)
			cms_pkg::MODE_IDLE: begin
				light_on_n = light_on_q ^ rise[cms_pkg::EDGE_LIGHT];
				if (rise[cms_pkg::EDGE_ZERO]) begin
					relay_n = 5'd0;
					relay_n[cms_pkg::RLY_LIGHT]     = relay_q[cms_pkg::RLY_LIGHT];
					relay_n[cms_pkg::RLY_SEAT_DOWN] = 1'b1;
					relay_n[cms_pkg::RLY_BACK_UP]   = 1'b1;
					move_start_we = 1'b1;
					mode_n        = cms_pkg::MODE_ZERO;
					done_n        = 1'b0;
				end else if (rise[cms_pkg::EDGE_WORK] && done_q) begin
					relay_n = 5'd0;
					relay_n[cms_pkg::RLY_LIGHT]     = relay_q[cms_pkg::RLY_LIGHT];
					relay_n[cms_pkg::RLY_SEAT_UP]   = 1'b1;
					relay_n[cms_pkg::RLY_BACK_DOWN] = 1'b1;
					move_start_we = 1'b1;
					mode_n        = cms_pkg::MODE_WORK;
				end else begin
					relay_n = manual_relays;
					relay_n[cms_pkg::RLY_LIGHT] = light_on_n;
				end
			end
			cms_pkg::MODE_ZERO: begin
				if (any_pressed || move_timeout) begin
					relay_n = {relay_q[cms_pkg::RLY_LIGHT], 4'd0};
					mode_n  = cms_pkg::MODE_IDLE;
					done_n  = ~any_pressed;
				end
			end
			cms_pkg::MODE_WORK: begin
				if (any_pressed || move_timeout) begin
					relay_n = {relay_q[cms_pkg::RLY_LIGHT], 4'd0};
					mode_n  = cms_pkg::MODE_IDLE;
					done_n  = 1'b0;
				end
			end
			default: begin
				relay_n = {relay_q[cms_pkg::RLY_LIGHT], 4'd0};
				mode_n  = cms_pkg::MODE_IDLE;
				done_n  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q       <= '0;
			last_raw_q     <= '0;
			for (int i = 0; i < NB; i++) begin
				change_time_q[i] <= 32'd0;
			end
			prev_edges_q   <= 3'd0;
			mode_q         <= cms_pkg::MODE_IDLE;
			done_q         <= 1'b0;
			move_start_q   <= 32'd0;
			light_on_q     <= 1'b0;
			relay_q        <= 5'd0;
			wd_last_q      <= 32'd0;
			wd_level_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
				stable_q       <= stable_n;
				last_raw_q     <= raw;
				for (int i = 0; i < NB; i++) begin
					if (changed[i]) begin
						change_time_q[i] <= now_s1;
					end
				end
				prev_edges_q <= cur_edges;
				mode_q       <= mode_n;
				done_q       <= done_n;
				light_on_q   <= light_on_n;
				relay_q      <= relay_n;
				if (move_start_we) begin
					move_start_q <= now_s1;
				end
				if (wd_fire) begin
					wd_last_q  <= now_s1;
					wd_level_q <= ~wd_level_q;
				end
			end
		end
	end

	assign seat_up_relay   = relay_q[cms_pkg::RLY_SEAT_UP];
	assign seat_down_relay = relay_q[cms_pkg::RLY_SEAT_DOWN];
	assign back_up_relay   = relay_q[cms_pkg::RLY_BACK_UP];
	assign back_down_relay = relay_q[cms_pkg::RLY_BACK_DOWN];
	assign light_relay     = relay_q[cms_pkg::RLY_LIGHT];
	assign watchdog_pin    = wd_level_q;
	assign mode            = mode_q;
	assign return_done     = done_q;

endmodule
